// ----- hdl/srnt_pkg.sv -----
// Shared types and constants for the selective-repeat NACK tracker.
// Used by srnt_out_reg and selective_repeat_nack_tracker; no dependencies.
package srnt_pkg;

  // Default bitmap depth (chunks per transfer)
  localparam int unsigned MAX_CHUNKS_DEF = 64;
  // Cap on NACK ranges reported per tick
  localparam int unsigned MAX_RESULTS    = 32;

  // Field widths
  localparam int unsigned LA_W    = 6;
  localparam int unsigned RANGE_W = 6;
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned OUT_DW  = 16;

  localparam logic [LA_W-1:0] LOOKAHEAD_RST = LA_W'(5);

  // Input beat kind (tuser)
  localparam logic FUNC_PKT  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Result kind (tuser)
  localparam logic KIND_NACK   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // nack_lo/nack_hi: first and last missing chunk of a run, inclusive
  typedef struct packed {
    logic               kind;
    logic [RANGE_W-1:0] nack_lo;
    logic [RANGE_W-1:0] nack_hi;
    logic               last;
  } result_t;

endpackage

// ----- hdl/srnt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies; contents are not reset.
module srnt_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/srnt_out_reg.sv -----
// Output register for result beats: holds one result until the sink takes it.
// Depends on srnt_pkg (result_t, field widths).
module srnt_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  srnt_pkg::result_t      item_i,
  output logic                   free_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [5:0] nack_lo, [11:6] nack_hi, [15:12] zero
  output logic [15:0]            m_axis_tdata_o,
  // [0] kind
  output logic                   m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);
  import srnt_pkg::*;

  logic    valid_q, valid_d;
  result_t item_q;

  assign free_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {(OUT_DW - 2 * RANGE_W)'(0), item_q.nack_hi, item_q.nack_lo};
  assign m_axis_tuser_o  = item_q.kind;
  assign m_axis_tlast_o  = item_q.last;

endmodule

// ----- hdl/selective_repeat_nack_tracker.sv -----
// Selective-repeat receiver NACK range generator, top level.
// Bitmap of received chunks lives in srnt_ram; results leave through
// srnt_out_reg. Depends on srnt_pkg.
//
// Usage:
//   Input beats (s_axis): tuser = 0 is a packet header (seq, total in tdata),
//   tuser = 1 is a NACK interval tick. A header marks its chunk received;
//   the first acceptable header latches the chunk total.
//   Output beats (m_axis): tuser = 0 is a NACK range (start/end inclusive),
//   tuser = 1 is the finish beat; tlast flags the final beat of a tick.
//   cfg_we_i writes scan_lookahead from cfg_wdata_i. The user must assert
//   it only while the block is idle; the block does not enforce this.
// Timing:
//   After reset the bitmap is cleared by a pass over all MAX_CHUNKS entries,
//   with s_axis_tready_o low. A header goes through accept, bitmap read and
//   update; a tick does one bitmap read and one evaluate step per index.
//   Results sit in an output register, so a new beat is taken while the last
//   result waits; if the sink stalls while a tick still has a range to hand
//   over, the scan holds until the output register frees.
module selective_repeat_nack_tracker #(
  parameter int unsigned MAX_CHUNKS = srnt_pkg::MAX_CHUNKS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration: scan_lookahead
  input  logic                       cfg_we_i,
  input  logic [srnt_pkg::LA_W-1:0]  cfg_wdata_i,
  // input stream
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // [31:0] seq, [63:32] total
  input  logic [63:0]                s_axis_tdata_i,
  // [0] func
  input  logic                       s_axis_tuser_i,
  // result stream
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // [5:0] nack_lo, [11:6] nack_hi, [15:12] zero
  output logic [15:0]                m_axis_tdata_o,
  // [0] kind
  output logic                       m_axis_tuser_o,
  output logic                       m_axis_tlast_o
);
  import srnt_pkg::*;

  localparam int unsigned IW   = $clog2(MAX_CHUNKS);
  localparam int unsigned CW   = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned SW   = IW + LA_W + 1;
  localparam int unsigned RC_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_PKT_RD  = 7'b0000100,
    ST_PKT_UPD = 7'b0001000,
    ST_SCAN_RD = 7'b0010000,
    ST_SCAN_EV = 7'b0100000,
    ST_FLUSH   = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [IW-1:0]   clr_idx_q, clr_idx_d;
  logic [CW-1:0]   total_q, total_d;
  logic [IW-1:0]   highest_q, highest_d;
  logic [CW-1:0]   got_cnt_q, got_cnt_d;
  logic            finished_q, finished_d;
  logic [LA_W-1:0] la_q;
  logic [IW-1:0]   seq_q, seq_d;
  logic [IW-1:0]   scan_i_q, scan_i_d;
  logic [IW-1:0]   last_idx_q, last_idx_d;
  logic            in_run_q, in_run_d;
  logic [IW-1:0]   run_start_q, run_start_d;
  logic [RC_W-1:0] run_cnt_q, run_cnt_d;
  logic            pend_v_q, pend_v_d;
  logic [IW-1:0]   pend_start_q, pend_start_d;
  logic [IW-1:0]   pend_end_q, pend_end_d;

  // RAM port signals
  logic          ram_we, ram_wdata, ram_re, ram_rdata;
  logic [IW-1:0] ram_waddr, ram_raddr;

  // output register interface
  logic    out_load, out_free;
  result_t out_item;

  // input fields
  logic              in_func;
  logic [SEQ_W-1:0]  in_seq, in_total;
  logic              in_accept;

  // scan helpers
  logic            total_bad;
  logic [CW-1:0]   tot_eff;
  logic [SW-1:0]   scan_sum, scan_lim;
  logic            run_done, at_end, stall, finish_ok;
  logic [IW-1:0]   run_s, run_e;

  assign in_func   = s_axis_tuser_i;
  assign in_seq    = s_axis_tdata_i[31:0];
  assign in_total  = s_axis_tdata_i[63:32];
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  // header checks and scan bound
  assign total_bad = (total_q == '0)
                     && ((in_total == '0) || (in_total > SEQ_W'(MAX_CHUNKS)));
  assign tot_eff   = (total_q == '0) ? CW'(in_total) : total_q;
  assign scan_sum  = SW'(highest_q) + SW'(la_q) + SW'(1);
  assign scan_lim  = (scan_sum > SW'(total_q)) ? SW'(total_q) : scan_sum;

  // run bookkeeping for the index under evaluation
  assign at_end    = (scan_i_q == last_idx_q);
  assign run_done  = (ram_rdata && in_run_q) || (!ram_rdata && at_end);
  assign run_s     = (!ram_rdata && !in_run_q) ? scan_i_q : run_start_q;
  assign run_e     = ram_rdata ? (scan_i_q - IW'(1)) : scan_i_q;
  assign stall     = run_done && pend_v_q && !out_free;
  assign finish_ok = (got_cnt_q >= total_q);

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_q <= LOOKAHEAD_RST;
    end else if (cfg_we_i) begin
      la_q <= cfg_wdata_i;
    end
  end

  // main sequencer
  always_comb begin
    state_d      = state_q;
    clr_idx_d    = clr_idx_q;
    total_d      = total_q;
    highest_d    = highest_q;
    got_cnt_d    = got_cnt_q;
    finished_d   = finished_q;
    seq_d        = seq_q;
    scan_i_d     = scan_i_q;
    last_idx_d   = last_idx_q;
    in_run_d     = in_run_q;
    run_start_d  = run_start_q;
    run_cnt_d    = run_cnt_q;
    pend_v_d     = pend_v_q;
    pend_start_d = pend_start_q;
    pend_end_d   = pend_end_q;
    ram_we       = 1'b0;
    ram_waddr    = clr_idx_q;
    ram_wdata    = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = seq_q;
    out_load     = 1'b0;
    out_item     = '{kind: KIND_NACK, nack_lo: RANGE_W'(pend_start_q),
                     nack_hi: RANGE_W'(pend_end_q), last: 1'b0};

    unique case (state_q)
      // zero the bitmap after reset
      ST_CLEAR: begin
        ram_we    = 1'b1;
        clr_idx_d = clr_idx_q + IW'(1);
        if (clr_idx_q == IW'(MAX_CHUNKS - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept && !finished_q) begin
          if (in_func == FUNC_PKT) begin
            if (!total_bad) begin
              total_d = tot_eff;
              if (in_seq < SEQ_W'(tot_eff)) begin
                seq_d   = IW'(in_seq);
                state_d = ST_PKT_RD;
              end
            end
          end else if (total_q != '0) begin
            last_idx_d = IW'(scan_lim - SW'(1));
            scan_i_d   = '0;
            in_run_d   = 1'b0;
            run_cnt_d  = '0;
            pend_v_d   = 1'b0;
            state_d    = ST_SCAN_RD;
          end
        end
      end

      ST_PKT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = seq_q;
        state_d   = ST_PKT_UPD;
      end

      // new chunk: set bit, raise highest, bump count
      ST_PKT_UPD: begin
        if (!ram_rdata) begin
          ram_we    = 1'b1;
          ram_waddr = seq_q;
          ram_wdata = 1'b1;
          got_cnt_d = got_cnt_q + CW'(1);
          if (seq_q > highest_q) begin
            highest_d = seq_q;
          end
        end
        state_d = ST_IDLE;
      end

      ST_SCAN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = scan_i_q;
        state_d   = ST_SCAN_EV;
      end

      // one index: close or open a run; a closed run waits in pend until
      // the next one shows whether it was the last
      ST_SCAN_EV: begin
        if (!stall) begin
          if (run_done && pend_v_q) begin
            out_load = 1'b1;
          end
          if (run_done) begin
            pend_v_d     = 1'b1;
            pend_start_d = run_s;
            pend_end_d   = run_e;
            run_cnt_d    = run_cnt_q + RC_W'(1);
            in_run_d     = 1'b0;
          end else if (!ram_rdata && !in_run_q) begin
            in_run_d    = 1'b1;
            run_start_d = scan_i_q;
          end
          if (at_end || (run_done && (run_cnt_q == RC_W'(MAX_RESULTS - 1)))) begin
            state_d = ST_FLUSH;
          end else begin
            scan_i_d = scan_i_q + IW'(1);
            state_d  = ST_SCAN_RD;
          end
        end
      end

      // hand over the final range, or the finish beat
      ST_FLUSH: begin
        if (pend_v_q) begin
          if (out_free) begin
            out_load      = 1'b1;
            out_item.last = 1'b1;
            pend_v_d      = 1'b0;
            state_d       = ST_IDLE;
          end
        end else if (finish_ok) begin
          if (out_free) begin
            out_load   = 1'b1;
            out_item   = '{kind: KIND_FINISH, nack_lo: '0, nack_hi: '0,
                           last: 1'b1};
            finished_d = 1'b1;
            state_d    = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_idx_q  <= '0;
      total_q    <= '0;
      highest_q  <= '0;
      got_cnt_q  <= '0;
      finished_q <= 1'b0;
      in_run_q   <= 1'b0;
      run_cnt_q  <= '0;
      pend_v_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_idx_q  <= clr_idx_d;
      total_q    <= total_d;
      highest_q  <= highest_d;
      got_cnt_q  <= got_cnt_d;
      finished_q <= finished_d;
      in_run_q   <= in_run_d;
      run_cnt_q  <= run_cnt_d;
      pend_v_q   <= pend_v_d;
    end
  end

  // scan and header payload
  always_ff @(posedge clk_i) begin
    seq_q        <= seq_d;
    scan_i_q     <= scan_i_d;
    last_idx_q   <= last_idx_d;
    run_start_q  <= run_start_d;
    pend_start_q <= pend_start_d;
    pend_end_q   <= pend_end_d;
  end

  // received-chunk bitmap
  srnt_ram #(
    .WIDTH (1),
    .DEPTH (MAX_CHUNKS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result output register
  srnt_out_reg u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (out_load),
    .item_i          (out_item),
    .free_o          (out_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking bench for selective_repeat_nack_tracker.
// Drives header and tick beats, predicts NACK/finish beats with an in-bench scoreboard.
// Depends on srnt_pkg and the tracker RTL.
module testbench;
  import srnt_pkg::*;

  localparam int QUIET_LIMIT  = 4000;  // cycles without any beat before giving up
  localparam int SETTLE_CYCLES = 200;  // longest tick scan plus margin
  localparam int N_ORDERED    = MAX_CHUNKS_DEF - 2;  // chunks 0 and 62 go in directed

  // Tracks received chunks and queues the beats each tick should produce
  class nack_scoreboard;
    bit               got_map[MAX_CHUNKS_DEF];
    bit [6:0]         chunk_total;
    bit [5:0]         highest_idx;
    bit [6:0]         got_count;
    bit               done;
    bit [LA_W-1:0]    lookahead;
    result_t          expected_q[$];
    int unsigned      errors;

    function new();
      lookahead = LOOKAHEAD_RST;
    endfunction

    // Append one expected beat at the tail
    function void queue_beat(result_t b);
      expected_q.insert(expected_q.size(), b);
    endfunction

    // Accepted input beat: update tracking state, queue any results
    function void note_beat(logic func, logic [31:0] seq, logic [31:0] total);
      int      scan_end;
      int      run_start;
      int      n_runs;
      bit      in_run;
      bit      have_prev;
      result_t prev;
      result_t fin;
      if (done) return;
      if (func == FUNC_PKT) begin
        if (chunk_total == 0) begin
          if (total == 0 || total > MAX_CHUNKS_DEF) return;
          chunk_total = total[6:0];
        end
        if (seq < chunk_total && !got_map[seq]) begin
          got_map[seq] = 1'b1;
          if (seq[5:0] > highest_idx) highest_idx = seq[5:0];
          got_count++;
        end
        return;
      end
      if (chunk_total == 0) return;
      scan_end = int'(highest_idx) + int'(lookahead) + 1;
      if (scan_end > int'(chunk_total)) scan_end = int'(chunk_total);
      n_runs = 0;
      in_run = 1'b0;
      have_prev = 1'b0;
      run_start = 0;
      // walk the window, one beat per run of missing chunks
      for (int i = 0; i < scan_end && n_runs < MAX_RESULTS; i++) begin
        if (!got_map[i]) begin
          if (!in_run) begin
            in_run = 1'b1;
            run_start = i;
          end
          if (i + 1 == scan_end || got_map[i + 1]) begin
            if (have_prev) queue_beat(prev);
            prev.kind    = KIND_NACK;
            prev.nack_lo = RANGE_W'(run_start);
            prev.nack_hi = RANGE_W'(i);
            prev.last    = 1'b0;
            have_prev = 1'b1;
            n_runs++;
            in_run = 1'b0;
          end
        end
      end
      if (have_prev) begin
        prev.last = 1'b1;
        queue_beat(prev);
      end else if (got_count >= chunk_total) begin
        fin.kind    = KIND_FINISH;
        fin.nack_lo = '0;
        fin.nack_hi = '0;
        fin.last    = 1'b1;
        queue_beat(fin);
        done = 1'b1;
      end
    endfunction

    function void compare_field(string name, int want, int seen);
      if (want != seen) begin
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, seen);
        errors++;
      end
    endfunction

    // Accepted result beat: compare against the oldest expectation
    function void check_result(result_t seen);
      result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual kind %0d range %0d..%0d last %0d",
                 $time, seen.kind, seen.nack_lo, seen.nack_hi, seen.last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("kind", want.kind, seen.kind);
      compare_field("nack_lo", want.nack_lo, seen.nack_lo);
      compare_field("nack_hi", want.nack_hi, seen.nack_hi);
      compare_field("last", want.last, seen.last);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [LA_W-1:0]   cfg_wdata_i = '0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [63:0]       s_axis_tdata_i = '0;   // [31:0] seq, [63:32] total
  logic              s_axis_tuser_i = 1'b0; // [0] func
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [15:0]       m_axis_tdata_o;        // [5:0] nack_lo, [11:6] nack_hi
  logic              m_axis_tuser_o;        // [0] kind
  logic              m_axis_tlast_o;
  result_t           out_beat;

  nack_scoreboard    sb;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                quiet_cycles = 0;
  int                chunk_order[N_ORDERED];

  selective_repeat_nack_tracker u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  assign out_beat = {m_axis_tuser_o, m_axis_tdata_o[5:0], m_axis_tdata_o[11:6], m_axis_tlast_o};

  // Result side: check accepted beats, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(out_beat);
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: too long without a beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input beat; valid stays high on return so back-to-back beats need no drop
  task automatic send_beat(input logic func, input logic [31:0] seq, input logic [31:0] total);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= func;
    s_axis_tdata_i  <= {total, seq};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_beat(func, seq, total);
  endtask

  // Drop valid, wait out all expected beats, then let any scan finish
  task automatic quiesce();
    s_axis_tvalid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_lookahead(input logic [LA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.lookahead = value;
  endtask

  // Mostly new chunks in shuffled order, with ticks, duplicates and stray indices
  task automatic run_random(input int first, input int count);
    int next;
    int pick;
    next = first;
    while (next < first + count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_beat(FUNC_PKT, 32'(chunk_order[next]), $urandom());
        next++;
      end else if (pick < 80) begin
        send_beat(FUNC_TICK, $urandom(), $urandom());
      end else if (pick < 90) begin
        send_beat(FUNC_PKT, (next == 0) ? 32'd0 : 32'(chunk_order[$urandom_range(0, next - 1)]),
                  $urandom());
      end else begin
        send_beat(FUNC_PKT, $urandom_range(0, 1) ? 32'($urandom_range(64, 127)) : $urandom(),
                  $urandom());
      end
    end
  endtask

  initial begin
    int j;
    int tmp;
    sb = new();
    // odd chunks first, then even ones, each half shuffled
    for (int k = 0; k < 32; k++) chunk_order[k] = 2 * k + 1;
    for (int k = 0; k < 30; k++) chunk_order[32 + k] = 2 * k + 2;
    for (int k = 31; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = chunk_order[k];
      chunk_order[k] = chunk_order[j];
      chunk_order[j] = tmp;
    end
    for (int k = N_ORDERED - 1; k > 32; k--) begin
      j = $urandom_range(32, k);
      tmp = chunk_order[k];
      chunk_order[k] = chunk_order[j];
      chunk_order[j] = tmp;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, default lookahead: ticks before latch, rejected totals, bad indices
    send_beat(FUNC_TICK, 32'd0, 32'd0);
    send_beat(FUNC_PKT, 32'd3, 32'd0);
    send_beat(FUNC_PKT, 32'd0, 32'd65);
    send_beat(FUNC_PKT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(FUNC_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(FUNC_PKT, 32'd64, 32'd64);
    send_beat(FUNC_TICK, 32'd0, 32'd0);
    send_beat(FUNC_PKT, 32'd0, 32'd0);
    send_beat(FUNC_PKT, 32'd0, 32'h5A5A_A5A5);
    send_beat(FUNC_PKT, 32'hFFFF_FFFF, 32'd1);
    send_beat(FUNC_PKT, 32'h8000_0000, 32'd64);
    send_beat(FUNC_TICK, 32'd0, 32'd0);

    // Zero lookahead: a fully received window reports nothing, then chunk 62 opens a gap
    quiesce();
    set_lookahead('0);
    send_beat(FUNC_TICK, 32'd0, 32'd0);
    send_beat(FUNC_PKT, 32'd62, 32'd0);
    send_beat(FUNC_TICK, 32'd0, 32'd0);

    // Random phases, one idling pattern each
    run_random(0, 16);
    quiesce();
    set_lookahead({LA_W{1'b1}});
    send_idle_pct = 55;
    run_random(16, 16);
    quiesce();
    set_lookahead(LA_W'($urandom_range(1, 62)));
    send_idle_pct = 0;
    recv_stall_pct = 55;
    run_random(32, 16);
    quiesce();
    set_lookahead(LA_W'($urandom_range(0, 63)));
    send_idle_pct = 16;
    recv_stall_pct = 16;
    run_random(48, N_ORDERED - 48);

    // All chunks in: finish, then everything is ignored
    send_beat(FUNC_TICK, $urandom(), $urandom());
    send_beat(FUNC_TICK, $urandom(), $urandom());
    send_beat(FUNC_PKT, 32'd5, 32'd64);
    quiesce();

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
